>>> design/assert_macros.svh
// Assertion macros shared by the filter RTL.
// Depends on nothing; ASSERT_OFF removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that prop holds at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that cond never holds at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> design/aemf_pkg.sv
// Types, constants and helpers for the adaptive EMA channel filter.
// Depends on nothing; used by adaptive_ema_channel_filter.
package aemf_pkg;

    // Channel bank
    localparam int NUM_CHANNELS = 16;
    localparam int CH_W         = 4;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Field widths
    localparam int SMP_W  = 10;
    localparam int Q8_W   = 18;
    localparam int Q12_W  = 13;
    localparam int TIME_W = 32;
    localparam int GMS_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;

    localparam logic [Q12_W-1:0] ONE_Q12 = 13'd4096;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADAPTIVE_MODE   = 3'd0,
        REG_FIXED_ALPHA     = 3'd1,
        REG_SLOW_ALPHA      = 3'd2,
        REG_FAST_ALPHA      = 3'd3,
        REG_CERT_STEP       = 3'd4,
        REG_GHOST_RESET_MS  = 3'd5,
        REG_REAL_THRESHOLD  = 3'd6,
        REG_GHOST_THRESHOLD = 3'd7
    } cfg_reg_t;

    // One channel's state word
    typedef struct packed {
        logic              zr_active;
        logic [TIME_W-1:0] zero_start;
        logic [Q12_W-1:0]  cert;
        logic [SMP_W-1:0]  prev_sample;
        logic [Q8_W-1:0]   prev_output;
    } aemf_entry_t;

    localparam aemf_entry_t ENTRY_RESET = '{
        zr_active:   1'b0,
        zero_start:  '0,
        cert:        ONE_Q12,
        prev_sample: '0,
        prev_output: '0
    };

    // Clamp a Q1.12 quantity to 1.0
    function automatic logic [Q12_W-1:0] sat_q12(input logic [Q12_W:0] v);
        logic [Q12_W-1:0] r;
        r = (v > {1'b0, ONE_Q12}) ? ONE_Q12 : v[Q12_W-1:0];
        return r;
    endfunction

endpackage

>>> design/adaptive_ema_channel_filter.sv
// Adaptive EMA channel filter: per-channel state memory, alpha and EMA datapath.
// Depends on aemf_pkg and assert_macros.svh.
//
// Channel  | Dir | Handshake         | Word
// ---------+-----+-------------------+---------------------------------------
// s_       | in  | s_tvalid/s_tready | channel, sample, now_ms
// m_       | out | m_tvalid/m_tready | out_channel, filtered, certainty
// cfg_     | in  | cfg_wr_en         | register index and value
//
// Each word passes through these steps in order: accept with state read, alpha
// product, alpha sum and X product, EMA sum, then update and write back. The
// chain of three multiplies through the one state memory sets this sequence.
// Reset is synchronous; per-channel valid bits make every entry read as its
// reset value at once, so no clearing pass is needed.
// A stalled result holds the write-back stage; the next word waits meanwhile.
`include "assert_macros.svh"

module adaptive_ema_channel_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: channel[3:0], sample[13:4], now_ms[45:14], zero pad
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [aemf_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata: out_channel[3:0], filtered[21:4], certainty[34:22], zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [aemf_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [aemf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aemf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_MUL, ST_ACC, ST_WB} state_t;

    state_t state_reg;
    logic   m_tvalid_reg;

    // Configuration registers
    logic                            adaptive_reg;
    logic [aemf_pkg::Q12_W-1:0]      fixed_alpha_reg;
    logic [aemf_pkg::Q12_W-1:0]      slow_alpha_reg;
    logic [aemf_pkg::Q12_W-1:0]      fast_alpha_reg;
    logic [aemf_pkg::Q12_W-1:0]      cert_step_reg;
    logic [aemf_pkg::GMS_W-1:0]      ghost_ms_reg;
    logic [aemf_pkg::Q8_W-1:0]       real_thr_reg;
    logic [aemf_pkg::Q8_W-1:0]       ghost_thr_reg;

    // Word in flight
    logic [aemf_pkg::CH_W-1:0]       ch_reg;
    logic [aemf_pkg::SMP_W-1:0]      smp_reg;
    logic [aemf_pkg::TIME_W-1:0]     now_reg;
    logic                            oor_reg;

    // State memory and its valid bits
    aemf_pkg::aemf_entry_t           mem [aemf_pkg::NUM_CHANNELS];
    aemf_pkg::aemf_entry_t           rd_data_reg;
    logic                            rd_vld_reg;
    logic [aemf_pkg::NUM_CHANNELS-1:0] ent_vld_reg;

    // Datapath registers
    aemf_pkg::aemf_entry_t           ent_reg;
    logic                            zc_drop_reg;
    logic                            zc_hold_reg;
    logic [2*aemf_pkg::Q12_W-1:0]    aprod_reg;
    logic [aemf_pkg::Q12_W-1:0]      a_reg;
    logic [30:0]                     p1_reg;
    logic [aemf_pkg::Q8_W-1:0]       y_reg;
    logic [aemf_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    logic                            s_accept;
    logic [aemf_pkg::CH_W-1:0]       s_ch;
    logic [aemf_pkg::CH_IDX_W-1:0]   s_idx;
    logic [aemf_pkg::CH_IDX_W-1:0]   wr_idx;
    logic                            out_load;
    logic                            mem_we;
    aemf_pkg::aemf_entry_t           ent_next;
    aemf_pkg::aemf_entry_t           wr_entry;
    logic [aemf_pkg::Q12_W-1:0]      slow_sat;
    logic [aemf_pkg::Q12_W-1:0]      fast_sat;
    logic [aemf_pkg::Q12_W-1:0]      fast_eff;
    logic [aemf_pkg::Q12_W-1:0]      span;
    logic [aemf_pkg::Q12_W-1:0]      step_sat;
    logic [aemf_pkg::Q12_W-1:0]      a_next;
    logic [aemf_pkg::Q8_W-1:0]       xq8_reg_w;
    logic [30:0]                     p2_prod;
    logic [31:0]                     acc_sum;
    logic [aemf_pkg::Q12_W-1:0]      cert_dec;
    logic [aemf_pkg::Q12_W-1:0]      cert_inc;
    logic [aemf_pkg::TIME_W-1:0]     run_len;
    logic [aemf_pkg::Q8_W-1:0]       y_res;
    logic [aemf_pkg::Q12_W-1:0]      c_res;
    logic [aemf_pkg::M_TDATA_W-1:0]  m_tdata_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_ch     = s_tdata[3:0];
    assign s_idx    = s_ch[aemf_pkg::CH_IDX_W-1:0];
    assign wr_idx   = ch_reg[aemf_pkg::CH_IDX_W-1:0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Load the result register once it is free
    assign out_load = (state_reg == ST_WB) && (!m_tvalid_reg || m_tready);
    assign mem_we   = out_load && !oor_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adaptive_reg    <= 1'b1;
            fixed_alpha_reg <= 13'd1024;
            slow_alpha_reg  <= 13'd410;
            fast_alpha_reg  <= 13'd2048;
            cert_step_reg   <= 13'd410;
            ghost_ms_reg    <= 16'd1000;
            real_thr_reg    <= 18'd51200;
            ghost_thr_reg   <= 18'd12800;
        end else if (cfg_wr_en) begin
            unique case (aemf_pkg::cfg_reg_t'(cfg_index))
                aemf_pkg::REG_ADAPTIVE_MODE:   adaptive_reg    <= cfg_wdata[0];
                aemf_pkg::REG_FIXED_ALPHA:     fixed_alpha_reg <= cfg_wdata[12:0];
                aemf_pkg::REG_SLOW_ALPHA:      slow_alpha_reg  <= cfg_wdata[12:0];
                aemf_pkg::REG_FAST_ALPHA:      fast_alpha_reg  <= cfg_wdata[12:0];
                aemf_pkg::REG_CERT_STEP:       cert_step_reg   <= cfg_wdata[12:0];
                aemf_pkg::REG_GHOST_RESET_MS:  ghost_ms_reg    <= cfg_wdata[15:0];
                aemf_pkg::REG_REAL_THRESHOLD:  real_thr_reg    <= cfg_wdata;
                aemf_pkg::REG_GHOST_THRESHOLD: ghost_thr_reg   <= cfg_wdata;
            endcase
        end
    end

    // State memory: read on accept, write back at the end of the word.
    // Only one word is in flight, so a read never overlaps a pending write.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx] <= wr_entry;
        end
        if (s_accept) begin
            rd_data_reg <= mem[s_idx];
        end
    end

    // Valid bits: an entry never written reads as its reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (mem_we) begin
                ent_vld_reg[wr_idx] <= 1'b1;
            end
            if (s_accept) begin
                rd_vld_reg <= ent_vld_reg[s_idx];
            end
        end
    end

    // Weights clamped to one; fast never below slow
    always_comb begin
        slow_sat = aemf_pkg::sat_q12({1'b0, slow_alpha_reg});
        fast_sat = aemf_pkg::sat_q12({1'b0, fast_alpha_reg});
        fast_eff = (fast_sat < slow_sat) ? slow_sat : fast_sat;
        span     = fast_eff - slow_sat;
        step_sat = aemf_pkg::sat_q12({1'b0, cert_step_reg});
        ent_next = rd_vld_reg ? rd_data_reg : aemf_pkg::ENTRY_RESET;
    end

    // Alpha sum in either mode, the (1 - alpha) product and the EMA sum
    always_comb begin
        if (adaptive_reg) begin
            a_next = aemf_pkg::sat_q12(14'(slow_sat) + 14'(aprod_reg[25:12]));
        end else begin
            a_next = aemf_pkg::sat_q12({1'b0, fixed_alpha_reg});
        end
        xq8_reg_w = {smp_reg, 8'd0};
        p2_prod   = (aemf_pkg::ONE_Q12 - a_reg) * ent_reg.prev_output;
        acc_sum   = 32'(p1_reg) + 32'(p2_prod);
    end

    // Certainty and zero-run update, and the result word
    always_comb begin
        cert_dec = (ent_reg.cert > step_sat) ? ent_reg.cert - step_sat : '0;
        cert_inc = aemf_pkg::sat_q12(14'(ent_reg.cert) + 14'(step_sat));
        run_len  = now_reg - ent_reg.zero_start;
        wr_entry = ent_reg;
        y_res    = y_reg;
        c_res    = ent_reg.cert;
        if (!adaptive_reg) begin
            wr_entry.prev_output = y_reg;
        end else begin
            wr_entry.prev_sample = smp_reg;
            priority if (zc_drop_reg) begin
                y_res                = '0;
                c_res                = cert_dec;
                wr_entry.prev_output = '0;
                wr_entry.zero_start  = now_reg;
                wr_entry.zr_active   = 1'b1;
            end else if (zc_hold_reg) begin
                y_res = '0;
                if (!ent_reg.zr_active) begin
                    wr_entry.zero_start = now_reg;
                    wr_entry.zr_active  = 1'b1;
                end else if (run_len >= 32'(ghost_ms_reg)) begin
                    c_res              = aemf_pkg::ONE_Q12;
                    wr_entry.zr_active = 1'b0;
                end
            end else begin
                if (y_reg > real_thr_reg && ent_reg.prev_output > real_thr_reg) begin
                    c_res = aemf_pkg::ONE_Q12;
                end else if (y_reg > ghost_thr_reg && ent_reg.prev_output > ghost_thr_reg) begin
                    c_res = cert_inc;
                end
                wr_entry.prev_output = y_reg;
                wr_entry.zr_active   = 1'b0;
            end
            wr_entry.cert = c_res;
        end
        if (oor_reg) begin
            m_tdata_next = {5'd0, 13'd0, 18'd0, ch_reg};
        end else begin
            m_tdata_next = {5'd0, c_res, y_res, ch_reg};
        end
    end

    // Sequencer and result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: if (s_accept) state_reg <= ST_RD;
                ST_RD:   state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_ACC;
                ST_ACC:  state_reg <= ST_WB;
                ST_WB:   if (out_load) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath stages
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ch_reg  <= s_ch;
            smp_reg <= s_tdata[13:4];
            now_reg <= s_tdata[45:14];
            oor_reg <= (32'(s_ch) >= 32'(aemf_pkg::NUM_CHANNELS));
        end
        if (state_reg == ST_RD) begin
            ent_reg     <= ent_next;
            zc_drop_reg <= (ent_next.prev_sample == '0) && (smp_reg == '0)
                           && (ent_next.prev_output != '0);
            zc_hold_reg <= (ent_next.prev_sample == '0) && (smp_reg == '0);
            aprod_reg   <= aemf_pkg::sat_q12({1'b0, ent_next.cert}) * span;
        end
        if (state_reg == ST_MUL) begin
            a_reg  <= a_next;
            p1_reg <= a_next * xq8_reg_w;
        end
        if (state_reg == ST_ACC) begin
            y_reg <= acc_sum[29:12];
        end
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Checks
    `ASSERT_PROP(a_accept_starts, aclk, aresetn,
        s_accept |=> state_reg == ST_RD, "accepted word did not start the read stage")
    `ASSERT_PROP(a_load_shows, aclk, aresetn,
        out_load |=> m_tvalid_reg, "loaded result not presented")
    `ASSERT_PROP(a_write_marks, aclk, aresetn,
        mem_we |=> ent_vld_reg[$past(wr_idx)], "written entry not marked valid")
    `ASSERT_NEVER(a_cert_range, aclk, aresetn,
        m_tvalid_reg && (m_tdata_reg[34:22] > aemf_pkg::ONE_Q12), "certainty above one")
    `ASSERT_NEVER(a_alpha_range, aclk, aresetn,
        (state_reg == ST_ACC) && (a_reg > aemf_pkg::ONE_Q12), "weight above one")

endmodule
